@@ rtl/bms_pkg.sv @@
package bms_pkg;

    localparam int KEY_W = 32;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_key;
        logic                    final_res;
        logic                    overflow;
    } t_out_item;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    last;
        logic                    store;
        logic                    ovf;
    } t_q_entry;

endpackage

@@ rtl/bms_ram.sv @@
module bms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

@@ rtl/bms_front.sv @@
module bms_front
    import bms_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    input  logic     i_full,
    output logic     o_push,
    output t_q_entry o_entry
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_drop;
    logic          n_drop;
    logic          store;

    assign o_push = i_start && !i_full;
    assign store  = (r_count < CW'(DEPTH));

    assign o_entry.key   = i_item.key;
    assign o_entry.last  = i_item.last;
    assign o_entry.store = store;
    assign o_entry.ovf   = r_drop || !store;

    always_comb begin
        n_count = r_count;
        n_drop  = r_drop;
        if (o_push) begin
            if (i_item.last) begin
                n_count = '0;
                n_drop  = 1'b0;
            end else begin
                n_count = r_count + CW'(store);
                n_drop  = r_drop || !store;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

endmodule

@@ rtl/bms_queue.sv @@
module bms_queue
    import bms_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    input  logic     i_pop,
    output t_q_entry o_head,
    output logic     o_empty,
    output logic     o_full
);

    localparam int QD = 4;
    localparam int PW = $clog2(QD);

    t_q_entry     r_mem [QD];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PW+1)'(QD));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

@@ rtl/bms_back.sv @@
module bms_back
    import bms_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_entry  i_head,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(DEPTH) + 2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SETUP,
        S_MERGE,
        S_ESETUP,
        S_EMIT
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_wp, n_wp;
    logic [IW-1:0] r_n, n_n;
    logic          r_ovf, n_ovf;
    logic          r_src, n_src;
    logic [IW-1:0] r_half, n_half;
    logic [IW-1:0] r_start, n_start;
    logic [IW-1:0] r_l, n_l;
    logic [IW-1:0] r_r, n_r;
    logic [IW-1:0] r_k, n_k;
    logic [IW-1:0] r_le, n_le;
    logic [IW-1:0] r_end, n_end;

    logic [IW-1:0]    mid;
    logic [IW-1:0]    seg_end;
    logic [IW-1:0]    left_end;
    logic             take_left;
    logic             we_a;
    logic             we_b;
    logic [AW-1:0]    waddr;
    logic [KEY_W-1:0] wdata;
    logic [KEY_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
    logic [KEY_W-1:0] rd0, rd1;

    bms_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk    (i_clk),
        .i_we     (we_a),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (n_l[AW-1:0]),
        .i_raddr1 (n_r[AW-1:0]),
        .o_rdata0 (a_rd0),
        .o_rdata1 (a_rd1)
    );

    bms_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk    (i_clk),
        .i_we     (we_b),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (n_l[AW-1:0]),
        .i_raddr1 (n_r[AW-1:0]),
        .o_rdata0 (b_rd0),
        .o_rdata1 (b_rd1)
    );

    assign rd0 = r_src ? b_rd0 : a_rd0;
    assign rd1 = r_src ? b_rd1 : a_rd1;

    // Run bounds, clipped to the array length.
    always_comb begin
        mid     = r_start + r_half;
        seg_end = r_start + (r_half << 1);
        if (seg_end > r_n) begin
            seg_end = r_n;
        end
        left_end = (mid < seg_end) ? mid : seg_end;
    end

    // Equal keys: left run wins.
    assign take_left = (r_l < r_le) &&
                       ((r_r >= r_end) || ($signed(rd0) <= $signed(rd1)));

    always_comb begin
        n_state = r_state;
        n_wp    = r_wp;
        n_n     = r_n;
        n_ovf   = r_ovf;
        n_src   = r_src;
        n_half  = r_half;
        n_start = r_start;
        n_l     = r_l;
        n_r     = r_r;
        n_k     = r_k;
        n_le    = r_le;
        n_end   = r_end;
        o_pop   = 1'b0;
        we_a    = 1'b0;
        we_b    = 1'b0;
        waddr   = r_wp[AW-1:0];
        wdata   = KEY_W'(i_head.key);
        case (r_state)
            S_LOAD: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_head.store) begin
                        we_a = 1'b1;
                        n_wp = r_wp + 1'b1;
                    end
                    if (i_head.last) begin
                        n_n     = r_wp + IW'(i_head.store);
                        n_ovf   = i_head.ovf;
                        n_wp    = '0;
                        n_src   = 1'b0;
                        n_start = '0;
                        n_half  = IW'(1);
                        n_state = (n_n > IW'(1)) ? S_SETUP : S_ESETUP;
                    end
                end
            end
            S_SETUP: begin
                n_l     = r_start;
                n_r     = mid;
                n_k     = r_start;
                n_le    = left_end;
                n_end   = seg_end;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                waddr = r_k[AW-1:0];
                wdata = take_left ? rd0 : rd1;
                we_a  = r_src;
                we_b  = !r_src;
                n_k   = r_k + 1'b1;
                if (take_left) begin
                    n_l = r_l + 1'b1;
                end else begin
                    n_r = r_r + 1'b1;
                end
                if (n_k == r_end) begin
                    if (r_end == r_n) begin
                        n_src   = !r_src;
                        n_half  = r_half << 1;
                        n_start = '0;
                        n_state = (n_half < r_n) ? S_SETUP : S_ESETUP;
                    end else begin
                        n_start = r_end;
                        n_state = S_SETUP;
                    end
                end
            end
            S_ESETUP: begin
                n_l     = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_l = r_l + 1'b1;
                if (n_l == r_n) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_wp    <= '0;
            r_n     <= '0;
            r_ovf   <= 1'b0;
            r_src   <= 1'b0;
            r_half  <= '0;
            r_start <= '0;
            r_l     <= '0;
            r_r     <= '0;
            r_k     <= '0;
            r_le    <= '0;
            r_end   <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_n     <= n_n;
            r_ovf   <= n_ovf;
            r_src   <= n_src;
            r_half  <= n_half;
            r_start <= n_start;
            r_l     <= n_l;
            r_r     <= n_r;
            r_k     <= n_k;
            r_le    <= n_le;
            r_end   <= n_end;
        end
    end

    assign o_valid             = (r_state == S_EMIT);
    assign o_result.sorted_key = rd0;
    assign o_result.final_res  = ((r_l + 1'b1) == r_n);
    assign o_result.overflow   = r_ovf;

endmodule

@@ rtl/bottom_up_merge_sort_unit.sv @@
// Keys enter one per cycle through a 4-entry queue while busy is low; busy rises only when it fills.
// For n stored keys the sort makes ceil(log2 n) merge passes, each pair of runs preceded by a setup
// step (S_SETUP); the single-write RAM port per buffer limits merging to one key per cycle.
// After the last key's dequeue the passes run, then S_ESETUP, and S_EMIT gives results one per cycle.
// Results are strobed on o_valid for one cycle each; the receiver cannot stall.
// Synchronous active-low reset clears counters, queue and sequencer; buffers are not cleared.
module bottom_up_merge_sort_unit
    import bms_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_empty;
    t_q_entry w_entry;
    t_q_entry w_head;

    bms_front #(.DEPTH(DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    bms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    bms_back #(.DEPTH(DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    assign busy = w_full;

endmodule
